/* rtl/svang_pkg.sv */
// shared constants, word types and the cordic step angle table for the vector angle core
package svang_pkg;

  // coordinate and angle formats
  localparam int CW          = 16;
  localparam int AFB         = 13;
  localparam int ANGLE_STEPS = 16;
  localparam int OUT_W       = AFB + 3;

  // exact products and their magnitudes
  localparam int MAG_W      = 2 * CW;
  localparam int NORM_STEPS = $clog2(MAG_W);
  localparam int SHIFT_W    = NORM_STEPS;

  // magnitudes enter the cordic with this many significant bits
  localparam int NORM_BITS = 29;
  localparam int NORM_W    = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;

  // cordic datapath
  localparam int XY_W   = 32;
  localparam int Z_FRAC = 30;
  localparam int Z_W    = 34;
  localparam int STEP_W = $clog2(ANGLE_STEPS);
  localparam int RS     = Z_FRAC - AFB;

  localparam logic signed [Z_W-1:0] PI_Z30      = Z_W'(64'sd3373259426);
  localparam logic signed [Z_W-1:0] HALF_PI_Z30 = Z_W'(64'sd1686629713);
  localparam logic signed [Z_W-1:0] ROUND_HALF  = Z_W'(1) << (RS - 1);
  localparam logic signed [Z_W-1:0] PIQ_Z       = (PI_Z30 + ROUND_HALF) >>> RS;
  localparam logic signed [OUT_W-1:0] PIQ_OUT   = OUT_W'(PIQ_Z);

  // registers from accepted word to result strobe
  localparam int LATENCY = 5 + NORM_STEPS + ANGLE_STEPS;

  typedef enum logic [1:0] {
    CODE_NORMAL,
    CODE_ZERO,
    CODE_PI
  } ang_code_e;

  // word moving down the normalization cells
  typedef struct packed {
    logic             valid;
    ang_code_e        code;
    logic             xneg;
    logic             yneg;
    logic [MAG_W-1:0] xm;
    logic [MAG_W-1:0] ym;
  } norm_word_t;

  // word moving down the cordic cells
  typedef struct packed {
    logic                   valid;
    ang_code_e              code;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_word_t;

  // atan(2^-i) in q30, exact powers of two from step ten on
  function automatic logic signed [Z_W-1:0] step_angle(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] res;
    res = '0;
    unique case (int'(idx))
      0: res = Z_W'(843314856);
      1: res = Z_W'(497837829);
      2: res = Z_W'(263043836);
      3: res = Z_W'(133525158);
      4: res = Z_W'(67021686);
      5: res = Z_W'(33543515);
      6: res = Z_W'(16775850);
      7: res = Z_W'(8388437);
      8: res = Z_W'(4194282);
      9: res = Z_W'(2097149);
      default: begin
        if (int'(idx) <= Z_FRAC) res[Z_FRAC - int'(idx)] = 1'b1;
      end
    endcase
    return res;
  endfunction

endpackage

/* rtl/svang_norm_cell.sv */
// one normalization cell: shifts both magnitudes left by a fixed amount when the top bits are clear
module svang_norm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [svang_pkg::SHIFT_W-1:0] amt_i,
  input  svang_pkg::norm_word_t       word_i,
  output svang_pkg::norm_word_t       word_o
);

  logic [svang_pkg::MAG_W-1:0] mask;
  logic                        top_clear;
  svang_pkg::norm_word_t       word_d;
  svang_pkg::norm_word_t       word_q;
  logic                        valid_q;

  always_comb begin
    mask      = ~({svang_pkg::MAG_W{1'b1}} >> amt_i);
    top_clear = ((word_i.xm | word_i.ym) & mask) == '0;
    word_d    = word_i;
    if (top_clear) begin
      word_d.xm = word_i.xm << amt_i;
      word_d.ym = word_i.ym << amt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
  end

endmodule

/* rtl/svang_cordic_cell.sv */
// one vectoring cordic cell: rotates toward the x axis and accumulates the step angle
module svang_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [svang_pkg::STEP_W-1:0] step_i,
  input  svang_pkg::rot_word_t         word_i,
  output svang_pkg::rot_word_t         word_o
);

  logic signed [svang_pkg::XY_W-1:0] dx;
  logic signed [svang_pkg::XY_W-1:0] dy;
  logic signed [svang_pkg::XY_W-1:0] y_in;
  logic signed [svang_pkg::Z_W-1:0]  ang;
  svang_pkg::rot_word_t              word_d;
  svang_pkg::rot_word_t              word_q;
  logic                              valid_q;

  always_comb begin
    y_in   = $signed(word_i.y);
    dx     = y_in >>> step_i;
    dy     = $signed(word_i.x) >>> step_i;
    ang    = svang_pkg::step_angle(step_i);
    word_d = word_i;
    // y on the axis leaves the word as it is
    if (y_in > 0) begin
      word_d.x = word_i.x + dx;
      word_d.y = word_i.y - dy;
      word_d.z = word_i.z + ang;
    end else if (y_in < 0) begin
      word_d.x = word_i.x - dx;
      word_d.y = word_i.y + dy;
      word_d.z = word_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
  end

endmodule

/* rtl/signed_vector_angle_core.sv */
// top level: signed angle from a first to a second 2d vector, pipelined one pair per cycle
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------------
//  input     | start_i, taken when !busy_o  | first_x_i, first_y_i, second_x_i, second_y_i
//  result    | done_o, one cycle, no stall  | angle_o (radians, 13 fraction bits)
//
// a new word is taken every cycle; busy_o stays low, the pipeline never backs up
// registers from accepted word to result: products, sums, sign split, 5 normalization cells,
//   pre-rotation, 16 cordic cells and the rounding register
// reset clears only the valid flags of the stages, payload registers are left as they are
// the receiver cannot stall, each result shows on done_o for exactly one cycle
module signed_vector_angle_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [svang_pkg::CW-1:0]    first_x_i,
  input  logic signed [svang_pkg::CW-1:0]    first_y_i,
  input  logic signed [svang_pkg::CW-1:0]    second_x_i,
  input  logic signed [svang_pkg::CW-1:0]    second_y_i,
  output logic                               done_o,
  output logic signed [svang_pkg::OUT_W-1:0] angle_o
);

  localparam int MW = svang_pkg::MAG_W;

  // stage 1: four exact products
  logic                 prod_vld_q;
  logic signed [MW-1:0] p_xx_q, p_yy_q, p_xy_q, p_yx_q;

  // stage 2: dot and det
  logic                 sum_vld_q;
  logic signed [MW:0]   dot_q, det_q;

  // stage 3: sign and magnitude, special case code
  svang_pkg::norm_word_t nw [svang_pkg::NORM_STEPS+1];
  svang_pkg::norm_word_t split_d;
  svang_pkg::norm_word_t split_q;
  logic                  split_vld_q;
  logic signed [MW:0]    dot_abs, det_abs;

  // pre-rotation stage
  svang_pkg::rot_word_t                         rw [svang_pkg::ANGLE_STEPS+1];
  svang_pkg::rot_word_t                         pre_d;
  svang_pkg::rot_word_t                         pre_q;
  logic                                         pre_vld_q;
  logic [svang_pkg::NORM_W-1:0]                 xw, yw;
  logic [svang_pkg::NORM_BITS-1:0]              xmn, ymn;
  logic signed [svang_pkg::XY_W-1:0]            xpos, ypos;
  logic                                         x_is_neg, y_is_neg;

  // output stage
  logic signed [svang_pkg::Z_W-1:0]   z_round, z_shift, z_clamp;
  logic signed [svang_pkg::OUT_W-1:0] angle_d, angle_q;
  logic                               done_q;

  // the pipeline always advances
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      sum_vld_q   <= 1'b0;
      split_vld_q <= 1'b0;
      pre_vld_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      prod_vld_q  <= start_i & ~busy_o;
      sum_vld_q   <= prod_vld_q;
      split_vld_q <= sum_vld_q;
      pre_vld_q   <= nw[svang_pkg::NORM_STEPS].valid;
      done_q      <= rw[svang_pkg::ANGLE_STEPS].valid;
    end
  end

  // products: one multiplier each, registered
  always_ff @(posedge clk_i) begin
    p_xx_q <= MW'(first_x_i) * MW'(second_x_i);
    p_yy_q <= MW'(first_y_i) * MW'(second_y_i);
    p_xy_q <= MW'(first_x_i) * MW'(second_y_i);
    p_yx_q <= MW'(first_y_i) * MW'(second_x_i);
  end

  // dot = x1*x2 + y1*y2, det = x1*y2 - y1*x2, exact with one guard bit
  always_ff @(posedge clk_i) begin
    dot_q <= (MW+1)'(p_xx_q) + (MW+1)'(p_yy_q);
    det_q <= (MW+1)'(p_xy_q) - (MW+1)'(p_yx_q);
  end

  // split into sign and magnitude, flag the two special angles
  always_comb begin
    dot_abs         = dot_q[MW] ? -dot_q : dot_q;
    det_abs         = det_q[MW] ? -det_q : det_q;
    split_d.valid   = sum_vld_q;
    split_d.xneg    = dot_q[MW];
    split_d.yneg    = det_q[MW];
    split_d.xm      = dot_abs[MW-1:0];
    split_d.ym      = det_abs[MW-1:0];
    priority if ((dot_q == '0) && (det_q == '0)) begin
      split_d.code = svang_pkg::CODE_ZERO;
    end else if ((det_q == '0) && dot_q[MW]) begin
      split_d.code = svang_pkg::CODE_PI;
    end else begin
      split_d.code = svang_pkg::CODE_NORMAL;
    end
  end

  always_ff @(posedge clk_i) begin
    split_q <= split_d;
  end

  always_comb begin
    nw[0]       = split_q;
    nw[0].valid = split_vld_q;
  end

  // normalization: binary leading-zero shift, largest step first
  for (genvar k = 0; k < svang_pkg::NORM_STEPS; k++) begin : g_norm
    svang_norm_cell u_norm (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .amt_i  (svang_pkg::SHIFT_W'(1 << (svang_pkg::NORM_STEPS - 1 - k))),
      .word_i (nw[k]),
      .word_o (nw[k+1])
    );
  end

  // keep the top NORM_BITS bits of the msb-aligned magnitudes, then pre-rotate by +-pi/2
  always_comb begin
    xw       = svang_pkg::NORM_W'(nw[svang_pkg::NORM_STEPS].xm) << (svang_pkg::NORM_W - MW);
    yw       = svang_pkg::NORM_W'(nw[svang_pkg::NORM_STEPS].ym) << (svang_pkg::NORM_W - MW);
    xmn      = xw[svang_pkg::NORM_W-1 -: svang_pkg::NORM_BITS];
    ymn      = yw[svang_pkg::NORM_W-1 -: svang_pkg::NORM_BITS];
    xpos     = $signed(svang_pkg::XY_W'(xmn));
    ypos     = $signed(svang_pkg::XY_W'(ymn));
    x_is_neg = nw[svang_pkg::NORM_STEPS].xneg && (xmn != '0);
    y_is_neg = nw[svang_pkg::NORM_STEPS].yneg && (ymn != '0);
    pre_d.valid = nw[svang_pkg::NORM_STEPS].valid;
    pre_d.code  = nw[svang_pkg::NORM_STEPS].code;
    if (x_is_neg) begin
      // left half plane: rotate a quarter turn toward the right half
      pre_d.x = ypos;
      pre_d.y = y_is_neg ? -xpos : xpos;
      pre_d.z = y_is_neg ? -svang_pkg::HALF_PI_Z30 : svang_pkg::HALF_PI_Z30;
    end else begin
      pre_d.x = xpos;
      pre_d.y = y_is_neg ? -ypos : ypos;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  always_comb begin
    rw[0]       = pre_q;
    rw[0].valid = pre_vld_q;
  end

  // cordic chain, one step per cell
  for (genvar i = 0; i < svang_pkg::ANGLE_STEPS; i++) begin : g_cordic
    svang_cordic_cell u_cordic (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (svang_pkg::STEP_W'(i)),
      .word_i (rw[i]),
      .word_o (rw[i+1])
    );
  end

  // round half up to the output fraction, clamp to +-pi, apply special cases
  always_comb begin
    z_round = rw[svang_pkg::ANGLE_STEPS].z + svang_pkg::ROUND_HALF;
    z_shift = z_round >>> svang_pkg::RS;
    priority if (z_shift > svang_pkg::PIQ_Z) begin
      z_clamp = svang_pkg::PIQ_Z;
    end else if (z_shift < -svang_pkg::PIQ_Z) begin
      z_clamp = -svang_pkg::PIQ_Z;
    end else begin
      z_clamp = z_shift;
    end
    unique case (rw[svang_pkg::ANGLE_STEPS].code)
      svang_pkg::CODE_ZERO:   angle_d = '0;
      svang_pkg::CODE_PI:     angle_d = svang_pkg::PIQ_OUT;
      svang_pkg::CODE_NORMAL: angle_d = svang_pkg::OUT_W'(z_clamp);
      default:                angle_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

/* rtl/svang_checker.sv */
// port-level checker for the vector angle core, bound to the top level
module svang_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic signed [svang_pkg::CW-1:0]    first_x_i,
  input logic signed [svang_pkg::CW-1:0]    first_y_i,
  input logic signed [svang_pkg::CW-1:0]    second_x_i,
  input logic signed [svang_pkg::CW-1:0]    second_y_i,
  input logic                               done_o,
  input logic signed [svang_pkg::OUT_W-1:0] angle_o
);

  // every accepted word yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(svang_pkg::LATENCY) done_o)
    else $error("missing result after accepted word");

  // no result without a word accepted at the matching cycle
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, svang_pkg::LATENCY))
    else $error("result without matching accepted word");

  // results stay within -pi..pi
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((angle_o <= svang_pkg::PIQ_OUT) && (angle_o >= -svang_pkg::PIQ_OUT)))
    else $error("angle out of range");

  // a zero first vector gives a zero angle
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (first_x_i == '0) && (first_y_i == '0))
      |-> ##(svang_pkg::LATENCY) (angle_o == '0))
    else $error("nonzero angle for zero vector");

endmodule

bind signed_vector_angle_core svang_checker u_svang_checker (.*);

/* verif/tb_signed_vector_angle_core.sv */
// testbench for signed_vector_angle_core: directed and random vector pairs checked against a predictor
`timescale 1ns / 1ps

module tb_signed_vector_angle_core;

  // angle formats of the predictor, q30 accumulation and rounding down to AFB bits
  localparam longint ANG_PI_Q30      = 64'sd3373259426;
  localparam longint ANG_HALF_PI_Q30 = 64'sd1686629713;
  localparam int     ANG_DROP        = 30 - svang_pkg::AFB;
  localparam int     ANG_SIG_BITS    = 29;
  localparam int     STALL_LIMIT     = 2000;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start_i;
  logic                               busy_o;
  logic signed [svang_pkg::CW-1:0]    first_x_i;
  logic signed [svang_pkg::CW-1:0]    first_y_i;
  logic signed [svang_pkg::CW-1:0]    second_x_i;
  logic signed [svang_pkg::CW-1:0]    second_y_i;
  logic                               done_o;
  logic signed [svang_pkg::OUT_W-1:0] angle_o;

  logic signed [svang_pkg::OUT_W-1:0] angle_expect_q[$];
  int                                 error_count = 0;
  int                                 sender_idle_pct;
  int                                 stall_cycles;

  signed_vector_angle_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .done_o     (done_o),
    .angle_o    (angle_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // atan2(det, dot) through pre-rotation and vectoring cordic, rounded half up
  function automatic logic signed [svang_pkg::OUT_W-1:0] angle_from_vectors(
    input logic signed [svang_pkg::CW-1:0] ax,
    input logic signed [svang_pkg::CW-1:0] ay,
    input logic signed [svang_pkg::CW-1:0] bx,
    input logic signed [svang_pkg::CW-1:0] by
  );
    longint atan_q30 [10];
    longint dot, det, xm, ym, big, x, y, z, t, dx, dy, rot, ang, piq;
    int     len;
    int     i;
    atan_q30 = '{64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
                 64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
                 64'sd4194282, 64'sd2097149};
    dot = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
    det = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
    piq = (ANG_PI_Q30 + (64'sd1 <<< (ANG_DROP - 1))) >>> ANG_DROP;
    if (dot == 0 && det == 0) begin
      ang = 0;
    end else if (det == 0 && dot < 0) begin
      // opposite vectors land on +pi, never -pi
      ang = piq;
    end else begin
      xm = (dot < 0) ? -dot : dot;
      ym = (det < 0) ? -det : det;
      big = (xm > ym) ? xm : ym;
      len = 0;
      while (big != 0) begin
        big = big >>> 1;
        len++;
      end
      // common shift, larger magnitude gets exactly ANG_SIG_BITS bits
      if (len > ANG_SIG_BITS) begin
        xm = xm >>> (len - ANG_SIG_BITS);
        ym = ym >>> (len - ANG_SIG_BITS);
      end else begin
        xm = xm <<< (ANG_SIG_BITS - len);
        ym = ym <<< (ANG_SIG_BITS - len);
      end
      x = (dot < 0) ? -xm : xm;
      y = (det < 0) ? -ym : ym;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = ANG_HALF_PI_Q30;
        end else begin
          x = -y;
          y = t;
          z = -ANG_HALF_PI_Q30;
        end
      end
      for (i = 0; i < svang_pkg::ANGLE_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (i < 10) rot = atan_q30[i];
        else if (i <= 30) rot = 64'sd1 <<< (30 - i);
        else rot = 0;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + rot;
        end else if (y < 0) begin
          x = x - dx;
          y = y + dy;
          z = z - rot;
        end
      end
      ang = (z + (64'sd1 <<< (ANG_DROP - 1))) >>> ANG_DROP;
      if (ang > piq) ang = piq;
      if (ang < -piq) ang = -piq;
    end
    return ang[svang_pkg::OUT_W-1:0];
  endfunction

  // drive one word from a falling edge, hold it until taken, leave at the next falling edge
  task automatic send_vectors(
    input logic signed [svang_pkg::CW-1:0] ax,
    input logic signed [svang_pkg::CW-1:0] ay,
    input logic signed [svang_pkg::CW-1:0] bx,
    input logic signed [svang_pkg::CW-1:0] by
  );
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start_i = 1'b0;
      first_x_i = svang_pkg::CW'($urandom);
      @(negedge clk_i);
    end
    start_i    = 1'b1;
    first_x_i  = ax;
    first_y_i  = ay;
    second_x_i = bx;
    second_y_i = by;
    do @(posedge clk_i); while (busy_o);
    angle_expect_q.insert(angle_expect_q.size(), angle_from_vectors(ax, ay, bx, by));
    @(negedge clk_i);
  endtask

  task automatic test_extremes();
    send_vectors(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_vectors(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_vectors(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0);
    send_vectors(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_vectors(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_vectors(16'sd32767, 16'sd0, 16'sd0, 16'sd32767);
    send_vectors(16'sd32767, 16'sd0, 16'sd0, -16'sd32768);
    // tiny products, normalization shifts left
    send_vectors(16'sd1, 16'sd0, 16'sd1, 16'sd0);
    send_vectors(16'sd1, 16'sd0, 16'sd0, 16'sd1);
    send_vectors(16'sd1, 16'sd0, -16'sd1, -16'sd1);
    send_vectors(16'sd1, 16'sd0, -16'sd1, 16'sd1);
  endtask

  task automatic test_special_cases();
    // zero vectors give zero angle
    send_vectors(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_vectors(16'sd0, 16'sd0, 16'sd1234, -16'sd5);
    send_vectors(-16'sd32768, 16'sd7, 16'sd0, 16'sd0);
    // opposite directions give +pi
    send_vectors(16'sd1, 16'sd0, -16'sd1, 16'sd0);
    send_vectors(16'sd3, 16'sd4, -16'sd6, -16'sd8);
    send_vectors(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    // just short of pi on both sides, clamp territory
    send_vectors(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1);
    send_vectors(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
    send_vectors(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
    // zero dot, negative det
    send_vectors(16'sd5, 16'sd0, 16'sd0, -16'sd3);
    // dot negative with det of either sign, pre-rotation branches
    send_vectors(16'sd100, 16'sd0, -16'sd70, 16'sd70);
    send_vectors(16'sd100, 16'sd0, -16'sd70, -16'sd70);
  endtask

  task automatic test_random_pairs(input int count, input int idle_pct);
    logic signed [svang_pkg::CW-1:0] ax, ay, bx, by;
    logic signed [svang_pkg::CW-1:0] corner [5];
    int                              kind;
    int                              n;
    corner = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    sender_idle_pct = idle_pct;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      ax = svang_pkg::CW'($urandom);
      ay = svang_pkg::CW'($urandom);
      bx = svang_pkg::CW'($urandom);
      by = svang_pkg::CW'($urandom);
      if (kind == 4 || kind == 5) begin
        ax = svang_pkg::CW'(int'($urandom_range(0, 16)) - 8);
        ay = svang_pkg::CW'(int'($urandom_range(0, 16)) - 8);
        bx = svang_pkg::CW'(int'($urandom_range(0, 16)) - 8);
        by = svang_pkg::CW'(int'($urandom_range(0, 16)) - 8);
      end else if (kind == 6 || kind == 7) begin
        // near parallel or antiparallel, det small or zero
        bx = ax >>> $urandom_range(0, 3);
        by = ay >>> $urandom_range(0, 3);
        if ($urandom_range(0, 1) != 0) begin
          bx = -bx;
          by = -by;
        end
        if ($urandom_range(0, 1) != 0) by = by + svang_pkg::CW'(int'($urandom_range(0, 2)) - 1);
      end else if (kind == 8) begin
        if ($urandom_range(0, 1) != 0) begin
          ax = '0;
          ay = '0;
        end else begin
          bx = '0;
          by = '0;
        end
      end else if (kind == 9) begin
        ax = corner[$urandom_range(0, 4)];
        ay = corner[$urandom_range(0, 4)];
        bx = corner[$urandom_range(0, 4)];
        by = corner[$urandom_range(0, 4)];
      end
      send_vectors(ax, ay, bx, by);
    end
    sender_idle_pct = 0;
  endtask

  // each strobed angle against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (angle_expect_q.size() == 0) begin
        $display("%0t unexpected angle word: expected none actual %0d", $time, angle_o);
        error_count++;
      end else begin
        if (angle_o !== angle_expect_q[0]) begin
          $display("%0t angle mismatch: expected %0d actual %0d",
                   $time, angle_expect_q[0], angle_o);
          error_count++;
        end
        void'(angle_expect_q.pop_front());
      end
    end
  end

  // watchdog on cycles with neither a word taken nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    first_x_i       = '0;
    first_y_i       = '0;
    second_x_i      = '0;
    second_y_i      = '0;
    sender_idle_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_special_cases();
    test_random_pairs(240, 0);
    test_random_pairs(240, 46);
    test_random_pairs(240, 27);
    start_i = 1'b0;

    while (angle_expect_q.size() != 0) @(posedge clk_i);
    // catch any stray result behind the last one
    repeat (svang_pkg::LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/svang_pkg.sv
rtl/svang_norm_cell.sv
rtl/svang_cordic_cell.sv
rtl/signed_vector_angle_core.sv
rtl/svang_checker.sv
verif/tb_signed_vector_angle_core.sv
